>>> hw/rtl/ssct_pkg.sv
`default_nettype none

package ssct_pkg;

    // default sizing
    localparam int STEPS_DEF      = 120;
    localparam int WINDOW_DEF     = 5;
    localparam int NUM_SERVOS_DEF = 3;

    localparam int PULSE_W  = 12;
    localparam int SERVO_W  = 2;
    localparam int SPEED_W  = 2;
    localparam int CUR_W    = 16;
    localparam int LIMIT_W  = 15;
    localparam int WAIT_W   = 7;
    localparam int IDX_W    = 7;
    localparam int STEPW_W  = 5;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 15;

    // servos that own configuration registers
    localparam int CFG_SERVOS = 3;

    // result queue depth
    localparam int OUT_DEPTH = 4;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_OPEN_A   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_CLOSED_A = 3'd3;
    localparam logic [CFG_AW-1:0] REG_LIMIT    = 3'd6;

    // register reset values
    localparam logic [PULSE_W-1:0] OPEN_A_RST   = 12'd930;
    localparam logic [PULSE_W-1:0] OPEN_B_RST   = 12'd1900;
    localparam logic [PULSE_W-1:0] OPEN_C_RST   = 12'd1940;
    localparam logic [PULSE_W-1:0] CLOSED_A_RST = 12'd2010;
    localparam logic [PULSE_W-1:0] CLOSED_B_RST = 12'd985;
    localparam logic [PULSE_W-1:0] CLOSED_C_RST = 12'd800;
    localparam logic [LIMIT_W-1:0] LIMIT_RST    = 15'd2400;

    // speed codes and step waits
    localparam logic [SPEED_W-1:0] SPEED_FAST   = 2'd1;
    localparam logic [SPEED_W-1:0] SPEED_FASTER = 2'd2;
    localparam logic [STEPW_W-1:0] WAIT_SLOW    = 5'd20;
    localparam logic [STEPW_W-1:0] WAIT_FAST    = 5'd5;
    localparam logic [STEPW_W-1:0] WAIT_FASTER  = 5'd2;
    localparam logic [WAIT_W-1:0]  SETTLE_MS    = 7'd100;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        ST_IGNORED  = 3'd0,
        ST_STARTED  = 3'd1,
        ST_STEPPING = 3'd2,
        ST_TRIPPED  = 3'd3,
        ST_FINISHED = 3'd4
    } t_status;

    typedef struct packed {
        logic                    last;
        logic [IDX_W-1:0]        step_index;
        logic [WAIT_W-1:0]       wait_ms;
        t_status                 status;
        logic                    drive_on;
        logic [PULSE_W-1:0]      pulse_us;
    } t_result;

    // words handed to the result queue in one cycle (count is 0, 1 or 2)
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic logic [PULSE_W-1:0] open_reset(input int unsigned s);
        case (s)
            0:       return OPEN_A_RST;
            1:       return OPEN_B_RST;
            2:       return OPEN_C_RST;
            default: return '0;
        endcase
    endfunction

    function automatic logic [PULSE_W-1:0] closed_reset(input int unsigned s);
        case (s)
            0:       return CLOSED_A_RST;
            1:       return CLOSED_B_RST;
            2:       return CLOSED_C_RST;
            default: return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ssct_rq.sv
`default_nettype none

// small result queue; takes up to two words a cycle, gives one
module ssct_rq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ssct_pkg::t_push  i_push,
    output logic                  o_room,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output ssct_pkg::t_result     o_head
);

    localparam int DEPTH = ssct_pkg::OUT_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ssct_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= CNT_W'(DEPTH - 2));
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wp + PTR_W'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PTR_W'(i_push.count);
            r_rp  <= r_rp + PTR_W'(w_pop);
            r_cnt <= r_cnt + CNT_W'(i_push.count) - CNT_W'(w_pop);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/servo_sweep_current_trip_core.sv
`default_nettype none

// Current-guarded servo sweep.
// Slave stream: tuser is the item kind (start or step); a start word names the
// servo, direction, hold flag and speed, a step word carries a rail current
// sample in mA. Master stream: one or two result words per input word, tlast
// on the final one, tuser gives the result kind.
// Config port: one register per write, index per the register list, no read-back.
// Only to be written while no word is in flight.
// Throughput: one input word per cycle while the queue has room. Trip and
// final-step words give two results, so a long run of those is held to the
// master side's pace. An accepted word waits in the input register for room,
// is worked out into the result queue, and is offered from the queue head.
// The ramp keeps a running |delta|*i and divides it by the step count with one
// reciprocal multiply; that multiply is the longest path.
// Reset: sweep idle, widths and current limit back to their defaults, each
// servo's last width at its closed width, result queue empty.
// Stall: the queue holds four words; the input register hands its word on while
// at least two places are free, so tready drops only once more than two words
// wait in the queue.
module servo_sweep_current_trip_core #(
    parameter int STEPS      = ssct_pkg::STEPS_DEF,
    parameter int WINDOW     = ssct_pkg::WINDOW_DEF,
    parameter int NUM_SERVOS = ssct_pkg::NUM_SERVOS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [14:0] i_cfg_wdata,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // servo_sel[1:0], to_open[2], keep_driving[3], speed[5:4], current_ma[21:6], pad
    input  wire logic [23:0] s_axis_tdata,
    // func[0]
    input  wire logic [0:0]  s_axis_tuser,
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pulse_us[11:0], drive_on[12], wait_ms[19:13], step_index[26:20], pad
    output logic [31:0]      m_axis_tdata,
    // status[2:0]
    output logic [2:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int PW     = ssct_pkg::PULSE_W;
    localparam int SW     = $clog2(STEPS);
    localparam int ACC_W  = PW + SW;           // holds |delta| * (STEPS-1)
    localparam int DIV_SH = ACC_W + SW;
    localparam int M_W    = ACC_W + 2;
    localparam int PROD_W = ACC_W + M_W;
    // exact reciprocal for every acc below 2**ACC_W
    localparam logic [M_W-1:0] DIV_M =
        M_W'(((64'd1 << DIV_SH) + 64'(STEPS) - 64'd1) / 64'(STEPS));
    localparam int SUM_W  = ssct_pkg::CUR_W + $clog2(WINDOW);
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    typedef struct packed {
        ssct_pkg::t_func                   func;
        logic [ssct_pkg::SERVO_W-1:0]      servo_sel;
        logic                              to_open;
        logic                              keep_driving;
        logic [ssct_pkg::SPEED_W-1:0]      speed;
        logic signed [ssct_pkg::CUR_W-1:0] current_ma;
    } t_item;

    // configuration
    logic [PW-1:0]                    r_open   [NUM_SERVOS];
    logic [PW-1:0]                    r_closed [NUM_SERVOS];
    logic [ssct_pkg::LIMIT_W-1:0]     r_limit;

    // input register
    logic                             r_in_vld;
    t_item                            r_in;

    // sweep state
    logic [PW-1:0]                    r_last_w [NUM_SERVOS];
    logic                             r_sweeping;
    logic [SW-1:0]                    r_step;
    logic [ACC_W-1:0]                 r_acc;
    logic [PW-1:0]                    r_rstart;
    logic [PW-1:0]                    r_mag;
    logic                             r_neg;
    logic [ssct_pkg::SERVO_W-1:0]     r_active;
    logic                             r_hold;
    logic [ssct_pkg::STEPW_W-1:0]     r_wait;
    logic signed [ssct_pkg::CUR_W-1:0] r_win [WINDOW];
    logic signed [SUM_W-1:0]          r_sum;
    logic [POS_W-1:0]                 r_pos;

    // datapath
    logic                             w_fire;
    logic                             w_room;
    logic                             w_start_go;
    logic                             w_step_go;
    logic                             w_sel_ok;
    logic [PW-1:0]                    w_lw_sel;
    logic [PW-1:0]                    w_open_sel;
    logic [PW-1:0]                    w_closed_sel;
    logic [PW-1:0]                    w_end;
    logic                             w_neg;
    logic [PW-1:0]                    w_mag;
    logic [ssct_pkg::STEPW_W-1:0]     w_wait;
    logic signed [ssct_pkg::CUR_W-1:0] w_old;
    logic signed [SUM_W:0]            w_sum_new;
    logic [SUM_W-1:0]                 w_thr;
    logic                             w_trip;
    logic                             w_final;
    logic [PROD_W-1:0]                w_prod;
    logic [PW-1:0]                    w_q;
    logic [PW-1:0]                    w_pulse;
    logic [POS_W-1:0]                 n_pos;
    logic [ssct_pkg::IDX_W-1:0]       w_idx;
    ssct_pkg::t_push                  w_push;
    ssct_pkg::t_result                w_head;

    assign s_axis_tready = !r_in_vld || w_fire;
    assign w_fire        = r_in_vld && w_room;

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SERVOS; s++) begin
                r_open[s]   <= ssct_pkg::open_reset(s);
                r_closed[s] <= ssct_pkg::closed_reset(s);
            end
            r_limit <= ssct_pkg::LIMIT_RST;
        end else if (i_cfg_we) begin
            for (int s = 0; s < NUM_SERVOS; s++) begin
                if (s < ssct_pkg::CFG_SERVOS &&
                    i_cfg_addr == ssct_pkg::REG_OPEN_A + 3'(s)) begin
                    r_open[s] <= i_cfg_wdata[PW-1:0];
                end
                if (s < ssct_pkg::CFG_SERVOS &&
                    i_cfg_addr == ssct_pkg::REG_CLOSED_A + 3'(s)) begin
                    r_closed[s] <= i_cfg_wdata[PW-1:0];
                end
            end
            if (i_cfg_addr == ssct_pkg::REG_LIMIT) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // ---- input register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.func         <= ssct_pkg::t_func'(s_axis_tuser[0]);
            r_in.servo_sel    <= s_axis_tdata[1:0];
            r_in.to_open      <= s_axis_tdata[2];
            r_in.keep_driving <= s_axis_tdata[3];
            r_in.speed        <= s_axis_tdata[5:4];
            r_in.current_ma   <= $signed(s_axis_tdata[21:6]);
        end
    end

    // ---- start decode ----
    always_comb begin
        w_lw_sel     = '0;
        w_open_sel   = '0;
        w_closed_sel = '0;
        for (int s = 0; s < NUM_SERVOS; s++) begin
            if (r_in.servo_sel == ssct_pkg::SERVO_W'(s)) begin
                w_lw_sel     = r_last_w[s];
                w_open_sel   = r_open[s];
                w_closed_sel = r_closed[s];
            end
        end
    end

    assign w_sel_ok   = ({1'b0, r_in.servo_sel} < 3'(NUM_SERVOS));
    assign w_start_go = (r_in.func == ssct_pkg::FUNC_START) && !r_sweeping && w_sel_ok;
    assign w_step_go  = (r_in.func == ssct_pkg::FUNC_STEP) && r_sweeping;
    assign w_end      = r_in.to_open ? w_open_sel : w_closed_sel;
    assign w_neg      = (w_end < w_lw_sel);
    assign w_mag      = w_neg ? (w_lw_sel - w_end) : (w_end - w_lw_sel);

    always_comb begin
        case (r_in.speed)
            ssct_pkg::SPEED_FAST:   w_wait = ssct_pkg::WAIT_FAST;
            ssct_pkg::SPEED_FASTER: w_wait = ssct_pkg::WAIT_FASTER;
            default:                w_wait = ssct_pkg::WAIT_SLOW;
        endcase
    end

    // ---- current window: running sum against WINDOW * limit ----
    assign w_old     = r_win[r_pos];
    assign w_sum_new = $signed({r_sum[SUM_W-1], r_sum}) - (SUM_W+1)'(w_old)
                     + (SUM_W+1)'(r_in.current_ma);
    assign w_thr     = SUM_W'(r_limit) * SUM_W'(WINDOW);
    assign w_trip    = (w_sum_new > $signed({1'b0, w_thr}));
    assign n_pos     = (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + POS_W'(1);

    // ---- ramp: |delta|*i / STEPS by reciprocal, sign applied after ----
    assign w_prod  = PROD_W'(r_acc) * PROD_W'(DIV_M);
    assign w_q     = w_prod[DIV_SH +: PW];
    assign w_pulse = r_neg ? (r_rstart - w_q) : (r_rstart + w_q);
    assign w_final = (r_step == SW'(STEPS - 1));
    assign w_idx   = ssct_pkg::IDX_W'(r_step);

    // ---- result words ----
    always_comb begin
        w_push        = '0;
        w_push.first.status = ssct_pkg::ST_IGNORED;
        w_push.first.last   = 1'b1;
        w_push.second.status = ssct_pkg::ST_FINISHED;
        w_push.second.wait_ms = ssct_pkg::SETTLE_MS;
        w_push.second.step_index = w_idx;
        w_push.second.last  = 1'b1;
        if (w_fire) begin
            w_push.count = 2'd1;
            if (w_start_go) begin
                w_push.first.status = ssct_pkg::ST_STARTED;
            end else if (w_step_go) begin
                w_push.first.step_index = w_idx;
                if (w_trip) begin
                    w_push.count        = 2'd2;
                    w_push.first.status = ssct_pkg::ST_TRIPPED;
                    w_push.first.last   = 1'b0;
                end else begin
                    w_push.first.status   = ssct_pkg::ST_STEPPING;
                    w_push.first.pulse_us = w_pulse;
                    w_push.first.drive_on = 1'b1;
                    w_push.first.wait_ms  = ssct_pkg::WAIT_W'(r_wait);
                    if (w_final) begin
                        w_push.count      = 2'd2;
                        w_push.first.last = 1'b0;
                        if (r_hold) begin
                            w_push.second.pulse_us = w_pulse;
                            w_push.second.drive_on = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // ---- sweep state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweeping <= 1'b0;
            r_step     <= '0;
            r_acc      <= '0;
            r_rstart   <= '0;
            r_mag      <= '0;
            r_neg      <= 1'b0;
            r_active   <= '0;
            r_hold     <= 1'b0;
            r_wait     <= ssct_pkg::WAIT_SLOW;
            r_sum      <= '0;
            r_pos      <= '0;
            for (int s = 0; s < NUM_SERVOS; s++) begin
                r_last_w[s] <= ssct_pkg::closed_reset(s);
            end
        end else if (w_fire) begin
            if (w_start_go) begin
                r_sweeping <= 1'b1;
                r_step     <= '0;
                r_acc      <= '0;
                r_rstart   <= w_lw_sel;
                r_mag      <= w_mag;
                r_neg      <= w_neg;
                r_active   <= r_in.servo_sel;
                r_hold     <= r_in.keep_driving;
                r_wait     <= w_wait;
                r_sum      <= '0;
                r_pos      <= '0;
            end else if (w_step_go) begin
                r_sum <= w_sum_new[SUM_W-1:0];
                r_pos <= n_pos;
                if (w_trip) begin
                    r_sweeping <= 1'b0;
                end else begin
                    for (int s = 0; s < NUM_SERVOS; s++) begin
                        if (r_active == ssct_pkg::SERVO_W'(s)) begin
                            r_last_w[s] <= w_pulse;
                        end
                    end
                    r_step <= r_step + SW'(1);
                    r_acc  <= r_acc + ACC_W'(r_mag);
                    if (w_final) begin
                        r_sweeping <= 1'b0;
                    end
                end
            end
        end
    end

    // window samples: cleared on every accepted start
    always_ff @(posedge i_clk) begin
        if (w_fire && w_start_go) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_win[k] <= '0;
            end
        end else if (w_fire && w_step_go) begin
            r_win[r_pos] <= r_in.current_ma;
        end
    end

    // ---- result queue ----
    ssct_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_head  (w_head)
    );

    assign m_axis_tdata = {5'd0, w_head.step_index, w_head.wait_ms,
                           w_head.drive_on, w_head.pulse_us};
    assign m_axis_tuser = w_head.status;
    assign m_axis_tlast = w_head.last;

endmodule

`default_nettype wire

>>> hw/rtl/ssct_chk.sv
`default_nettype none

// port-level checks on the result stream
module ssct_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // a held word stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word withdrawn while stalled");

    // ignore and start replies are single words
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ssct_pkg::ST_IGNORED ||
                          m_axis_tuser == ssct_pkg::ST_STARTED) |-> m_axis_tlast)
        else $error("single-word reply without tlast");

    // a trip word is never last; its finish word follows
    a_trip_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ssct_pkg::ST_TRIPPED |-> !m_axis_tlast)
        else $error("trip word marked last");

    // drive off means no pulse
    a_drive_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[12] |-> m_axis_tdata[11:0] == 12'd0)
        else $error("pulse reported with drive off");

    // queue empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result word offered after reset");

endmodule

bind servo_sweep_current_trip_core ssct_chk u_ssct_chk (.*);

`default_nettype wire

>>> test/tb_servo_sweep_current_trip_core.sv
`timescale 1ns / 100ps

module tb_servo_sweep_current_trip_core;
    import ssct_pkg::*;

    // the package has no names for these two speed codes
    localparam logic [SPEED_W-1:0] SPEED_SLOW   = 2'd0;
    localparam logic [SPEED_W-1:0] SPEED_UNUSED = 2'd3;
    localparam int                 PHASES       = 6;
    localparam int                 PHASE_WORDS  = 250;

    // ------------------------------------------------------------------
    // Sweep tracker: mirrors the block's registers and sweep state, keeps
    // the results still owed by the block, and checks each one that arrives.
    // ------------------------------------------------------------------
    class ramp_tracker;
        logic [PULSE_W-1:0] open_w   [CFG_SERVOS];
        logic [PULSE_W-1:0] closed_w [CFG_SERVOS];
        logic [LIMIT_W-1:0] limit_ma;
        logic [PULSE_W-1:0] last_w   [CFG_SERVOS];
        bit                 sweeping;
        int                 step_no;
        int                 win [WINDOW_DEF];
        int                 win_sum;
        int                 win_ptr;
        logic [PULSE_W-1:0] ramp_from;
        logic [PULSE_W-1:0] ramp_to;
        logic [SERVO_W-1:0] servo;
        bit                 hold;
        logic [WAIT_W-1:0]  step_ms;
        t_result            due_results [$];
        int                 errors;
        int                 n_seen [5];

        function new();
            int i;
            open_w[0]   = OPEN_A_RST;
            open_w[1]   = OPEN_B_RST;
            open_w[2]   = OPEN_C_RST;
            closed_w[0] = CLOSED_A_RST;
            closed_w[1] = CLOSED_B_RST;
            closed_w[2] = CLOSED_C_RST;
            limit_ma    = LIMIT_RST;
            for (i = 0; i < CFG_SERVOS; i++)
                last_w[i] = closed_w[i];
            for (i = 0; i < WINDOW_DEF; i++)
                win[i] = 0;
            sweeping  = 1'b0;
            step_no   = 0;
            win_sum   = 0;
            win_ptr   = 0;
            ramp_from = '0;
            ramp_to   = '0;
            servo     = '0;
            hold      = 1'b0;
            step_ms   = WAIT_W'(WAIT_SLOW);
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] val);
            if (addr >= REG_OPEN_A && addr < REG_CLOSED_A)
                open_w[addr - REG_OPEN_A] = val[PULSE_W-1:0];
            else if (addr >= REG_CLOSED_A && addr < REG_LIMIT)
                closed_w[addr - REG_CLOSED_A] = val[PULSE_W-1:0];
            else if (addr == REG_LIMIT)
                limit_ma = val[LIMIT_W-1:0];
        endfunction

        function void push(logic [PULSE_W-1:0] p, logic d, t_status st,
                           logic [WAIT_W-1:0] w, int idx, logic l);
            t_result r;
            r.pulse_us   = p;
            r.drive_on   = d;
            r.status     = st;
            r.wait_ms    = w;
            r.step_index = idx[IDX_W-1:0];
            r.last       = l;
            due_results.push_back(r);
        endfunction

        // One accepted input word; returns 0 when the block should ignore it.
        function bit take_word(t_func fn, logic [SERVO_W-1:0] sel, logic to_open,
                               logic keep, logic [SPEED_W-1:0] spd,
                               logic signed [CUR_W-1:0] cur);
            int                 i;
            int                 idx;
            int                 delta;
            int                 q;
            logic [PULSE_W-1:0] pulse;
            if (fn == FUNC_START) begin
                if (sweeping || sel >= NUM_SERVOS_DEF) begin
                    push('0, 1'b0, ST_IGNORED, '0, 0, 1'b1);
                    return 1'b0;
                end
                for (i = 0; i < WINDOW_DEF; i++)
                    win[i] = 0;
                win_sum   = 0;
                win_ptr   = 0;
                servo     = sel;
                ramp_from = last_w[sel];
                ramp_to   = to_open ? open_w[sel] : closed_w[sel];
                hold      = keep;
                step_ms   = (spd == SPEED_FAST)   ? WAIT_W'(WAIT_FAST) :
                            (spd == SPEED_FASTER) ? WAIT_W'(WAIT_FASTER) :
                                                    WAIT_W'(WAIT_SLOW);
                step_no   = 0;
                sweeping  = 1'b1;
                push('0, 1'b0, ST_STARTED, '0, 0, 1'b1);
                return 1'b1;
            end
            if (!sweeping) begin
                push('0, 1'b0, ST_IGNORED, '0, 0, 1'b1);
                return 1'b0;
            end
            idx          = step_no;
            win_sum      = win_sum - win[win_ptr];
            win[win_ptr] = cur;
            win_sum      = win_sum + win[win_ptr];
            win_ptr      = (win_ptr + 1 >= WINDOW_DEF) ? 0 : win_ptr + 1;
            // trip on the window sum, i.e. the mean against the limit
            if (win_sum > WINDOW_DEF * int'(limit_ma)) begin
                sweeping = 1'b0;
                push('0, 1'b0, ST_TRIPPED, '0, idx, 1'b0);
                push('0, 1'b0, ST_FINISHED, SETTLE_MS, idx, 1'b1);
                return 1'b1;
            end
            delta          = int'(ramp_to) - int'(ramp_from);
            q              = (delta * idx) / STEPS_DEF;
            pulse          = PULSE_W'(int'(ramp_from) + q);
            last_w[servo]  = pulse;
            step_no        = idx + 1;
            if (step_no >= STEPS_DEF) begin
                sweeping = 1'b0;
                push(pulse, 1'b1, ST_STEPPING, step_ms, idx, 1'b0);
                if (hold)
                    push(pulse, 1'b1, ST_FINISHED, SETTLE_MS, idx, 1'b1);
                else
                    push('0, 1'b0, ST_FINISHED, SETTLE_MS, idx, 1'b1);
            end else begin
                push(pulse, 1'b1, ST_STEPPING, step_ms, idx, 1'b1);
            end
            return 1'b1;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        endtask

        task check_result(logic [31:0] data, logic [2:0] kind, logic tl);
            t_result want;
            if (due_results.size() == 0) begin
                report("result word with nothing due", data, 0);
            end else begin
                want = due_results.pop_front();
                n_seen[want.status]++;
                if (data[11:0] !== want.pulse_us)
                    report("pulse_us", data[11:0], want.pulse_us);
                if (data[12] !== want.drive_on)
                    report("drive_on", data[12], want.drive_on);
                if (kind !== want.status)
                    report("status", kind, want.status);
                if (data[19:13] !== want.wait_ms)
                    report("wait_ms", data[19:13], want.wait_ms);
                if (data[26:20] !== want.step_index)
                    report("step_index", data[26:20], want.step_index);
                if (tl !== want.last)
                    report("tlast", tl, want.last);
            end
        endtask
    endclass

    // ------------------------------------------------------------------
    // Block and its surroundings
    // ------------------------------------------------------------------
    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_AW-1:0]   i_cfg_addr;
    logic [CFG_DW-1:0]   i_cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata;   // servo_sel, to_open, keep_driving, speed, current_ma
    logic [0:0]          s_axis_tuser;   // func
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [31:0]         m_axis_tdata;   // pulse_us, drive_on, wait_ms, step_index
    logic [2:0]          m_axis_tuser;   // status
    logic                m_axis_tlast;

    ramp_tracker sb;

    // idling knobs, changed per phase; quiet switches all idling off
    int  gap_pct   = 20;
    int  stall_pct = 20;
    bit  quiet     = 1'b0;
    bit  calm      = 1'b1;   // current of this sweep kept at or under the limit
    int  n_sent    = 0;

    servo_sweep_current_trip_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hang guard.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: tready stalls in bursts of random length, changed on the
    // falling edge so the block sees it settled at the next rising edge.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // every result word taken is checked against the oldest one due
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // ------------------------------------------------------------------
    // Drivers. Entered and left on a falling edge. tvalid stays high from one
    // word to the next unless a gap is taken, so it never gets two updates in
    // one step.
    // ------------------------------------------------------------------
    task automatic send_word(input t_func fn, input logic [SERVO_W-1:0] sel,
                             input logic to_open, input logic keep,
                             input logic [SPEED_W-1:0] spd, input logic [CUR_W-1:0] cur,
                             output bit counted);
        if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {2'b00, cur, spd, keep, to_open, sel};
        do @(posedge i_clk); while (!s_axis_tready);
        counted = sb.take_word(fn, sel, to_open, keep, spd, cur);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Hold off input until the block owes nothing; every word yields a
    // result, so an empty due list leaves the pipeline empty too.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (sb.due_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        sb.set_reg(addr, val);
        @(negedge i_clk);
    endtask

    task automatic load_config(input logic [CFG_SERVOS-1:0][PULSE_W-1:0] ow,
                               input logic [CFG_SERVOS-1:0][PULSE_W-1:0] cw,
                               input logic [LIMIT_W-1:0] lim);
        for (int s = 0; s < CFG_SERVOS; s++)
            put_reg(REG_OPEN_A + CFG_AW'(s), CFG_DW'(ow[s]));
        for (int s = 0; s < CFG_SERVOS; s++)
            put_reg(REG_CLOSED_A + CFG_AW'(s), CFG_DW'(cw[s]));
        put_reg(REG_LIMIT, lim);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed sweeps: a start, then steps until finish or trip.
    // Calm sweeps keep each sample at or under the limit so they run to the
    // end; the rest use any current and usually trip. Stray steps while idle
    // and starts mid-sweep are thrown in as noise.
    task automatic random_word(output bit counted);
        logic [SERVO_W-1:0] sel;
        logic [CUR_W-1:0]   cur;
        cur = $urandom_range(0, 65535);
        if (!sb.sweeping) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(FUNC_STEP, $urandom_range(0, 3), $urandom_range(0, 1),
                          $urandom_range(0, 1), $urandom_range(0, 3), cur, counted);
            end else begin
                // servo 3 has no registers and must be refused
                sel  = ($urandom_range(0, 9) == 0) ? 2'd3 : SERVO_W'($urandom_range(0, 2));
                calm = $urandom_range(0, 1);
                send_word(FUNC_START, sel, $urandom_range(0, 1), $urandom_range(0, 1),
                          $urandom_range(0, 3), cur, counted);
            end
        end else if ($urandom_range(0, 49) == 0) begin
            send_word(FUNC_START, $urandom_range(0, 3), $urandom_range(0, 1),
                      $urandom_range(0, 1), $urandom_range(0, 3), cur, counted);
        end else begin
            if (calm) begin
                if ($urandom_range(0, 9) == 0)
                    cur = -$urandom_range(0, 32768);
                else
                    cur = $urandom_range(0, sb.limit_ma);
            end
            send_word(FUNC_STEP, $urandom_range(0, 3), $urandom_range(0, 1),
                      $urandom_range(0, 1), $urandom_range(0, 3), cur, counted);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        bit                                     counted;
        int                                     taken;
        logic [CFG_SERVOS-1:0][PULSE_W-1:0]     ow;
        logic [CFG_SERVOS-1:0][PULSE_W-1:0]     cw;
        logic [LIMIT_W-1:0]                     lim;

        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_OPEN_A;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_START;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset register values (limit 2400, trip above 12000).
        // Stray step while idle, start for the servo with no registers.
        send_word(FUNC_STEP,  2'd0, 1'b0, 1'b0, SPEED_SLOW, 16'd0, counted);
        send_word(FUNC_START, 2'd3, 1'b1, 1'b1, SPEED_SLOW, 16'd0, counted);
        // Servo 0 towards open, held; a second start mid-sweep is refused.
        send_word(FUNC_START, 2'd0, 1'b1, 1'b1, SPEED_SLOW, 16'd0, counted);
        send_word(FUNC_START, 2'd2, 1'b0, 1'b0, SPEED_FAST, 16'd0, counted);
        // Current extremes; window sum lands exactly on the limit, then one over.
        send_word(FUNC_STEP,  2'd0, 1'b0, 1'b0, SPEED_SLOW, 16'h8000, counted);
        send_word(FUNC_STEP,  2'd3, 1'b1, 1'b1, SPEED_UNUSED, 16'h7FFF, counted);
        send_word(FUNC_STEP,  2'd0, 1'b0, 1'b0, SPEED_SLOW, 16'd0, counted);
        send_word(FUNC_STEP,  2'd0, 1'b0, 1'b0, SPEED_SLOW, 16'd12001, counted);
        send_word(FUNC_STEP,  2'd0, 1'b0, 1'b0, SPEED_SLOW, 16'd1, counted);
        // Servo 1 towards closed, fast, released on finish; trips on a spike.
        send_word(FUNC_START, 2'd1, 1'b0, 1'b0, SPEED_FAST, 16'd0, counted);
        send_word(FUNC_STEP,  2'd0, 1'b0, 1'b0, SPEED_SLOW, 16'd100, counted);
        send_word(FUNC_STEP,  2'd0, 1'b0, 1'b0, SPEED_SLOW, 16'hFFFF, counted);
        send_word(FUNC_STEP,  2'd0, 1'b0, 1'b0, SPEED_SLOW, 16'h7FFF, counted);
        // Servo 2 at the fastest speed.
        send_word(FUNC_START, 2'd2, 1'b1, 1'b1, SPEED_FASTER, 16'd0, counted);
        send_word(FUNC_STEP,  2'd0, 1'b0, 1'b0, SPEED_SLOW, 16'd5, counted);
        send_word(FUNC_STEP,  2'd0, 1'b0, 1'b0, SPEED_SLOW, 16'h7FFF, counted);
        // Speed code 3 falls back to the slow wait; left sweeping on purpose.
        send_word(FUNC_START, 2'd0, 1'b0, 1'b0, SPEED_UNUSED, 16'd0, counted);
        send_word(FUNC_STEP,  2'd0, 1'b0, 1'b0, SPEED_SLOW, 16'd2400, counted);
        send_word(FUNC_STEP,  2'd0, 1'b0, 1'b0, SPEED_SLOW, 16'd2400, counted);
        send_word(FUNC_START, 2'd3, 1'b0, 1'b1, SPEED_FAST, 16'd0, counted);
        // sender waits here until the block owes nothing
        settle_block();

        // Random phases, each under a different register setting. The sweep
        // state carries over the register writes, which happen only when idle.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                settle_block();
                for (int s = 0; s < CFG_SERVOS; s++) begin
                    ow[s] = $urandom_range(0, 4095);
                    cw[s] = $urandom_range(0, 4095);
                end
                case (ph)
                    1: lim = $urandom_range(500, 6000);
                    2: begin
                        // widest ramps upward; limit so high nothing trips
                        ow  = {CFG_SERVOS{12'hFFF}};
                        cw  = '0;
                        lim = 15'h7FFF;
                    end
                    3: begin
                        // widest ramps downward; zero limit
                        ow  = '0;
                        cw  = {CFG_SERVOS{12'hFFF}};
                        lim = '0;
                    end
                    4: lim = $urandom_range(0, 32767);
                    default: lim = $urandom_range(1000, 4000);
                endcase
                load_config(ow, cw, lim);
            end
            if (ph == PHASES - 1) begin
                quiet = 1'b1;
            end else begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            end
            taken = 0;
            while (taken < PHASE_WORDS) begin
                random_word(counted);
                if (counted)
                    taken++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d words over %0d register settings; results: %0d started,",
                 n_sent, PHASES, sb.n_seen[ST_STARTED]);
        $display("%0d steps, %0d trips, %0d finishes, %0d ignored; %0d mismatches",
                 sb.n_seen[ST_STEPPING], sb.n_seen[ST_TRIPPED], sb.n_seen[ST_FINISHED],
                 sb.n_seen[ST_IGNORED], sb.errors);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ssct_pkg.sv
hw/rtl/ssct_rq.sv
hw/rtl/servo_sweep_current_trip_core.sv
hw/rtl/ssct_chk.sv
test/tb_servo_sweep_current_trip_core.sv
